>>> sv/sts_pkg.sv
// shared types and codes for the sorted table search block
`timescale 1ns / 1ps

package sts_pkg;

  // request codes carried by the command field
  localparam logic [0:0] CMD_LOAD   = 1'b0;
  localparam logic [0:0] CMD_LOOKUP = 1'b1;

  // operation strobes of the table port
  typedef struct packed {
    logic wr;
    logic rd;
  } mem_op_t;

endpackage

>>> sv/sts_table.sv
// single port key table with a registered read
`timescale 1ns / 1ps

module sts_table #(
  parameter int DEPTH = 8192,
  parameter int AW    = 13,
  parameter int KW    = 40
) (
  input  logic            clk,
  input  sts_pkg::mem_op_t op,
  input  logic [AW-1:0]   addr,
  input  logic [KW-1:0]   wr_data,
  output logic [KW-1:0]   rd_data
);
  import sts_pkg::*;

  logic [KW-1:0] mem [DEPTH];

  // one access a cycle, write wins
  always_ff @(posedge clk) begin
    if (op.wr) begin
      mem[addr] <= wr_data;
    end else if (op.rd) begin
      rd_data <= mem[addr];
    end
  end

endmodule

>>> sv/sts_search.sv
// binary search sequencer, one table probe per cycle
`timescale 1ns / 1ps

module sts_search #(
  parameter int AW = 13,
  parameter int CW = 14,
  parameter int KW = 40
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [KW-1:0]    start_key,
  input  logic [CW-1:0]    start_count,
  input  logic [KW-1:0]    rd_data,
  output sts_pkg::mem_op_t op,
  output logic [AW-1:0]    addr,
  output logic             busy,
  output logic             res_valid,
  output logic             res_found,
  input  logic             res_take
);
  import sts_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_PROBE = 2'd1;
  localparam logic [1:0] S_DONE  = 2'd2;

  logic [1:0]    state, state_next;
  logic [CW-1:0] lo, lo_next;
  logic [CW-1:0] hi, hi_next;
  logic [AW-1:0] mid, mid_next;
  logic [KW-1:0] key, key_next;
  logic          found_r, found_r_next;

  logic [CW-1:0] cnt_m1;
  logic [CW-1:0] mid0;
  logic [CW-1:0] lo_n;
  logic [CW-1:0] hi_n;
  logic [CW:0]   span_sum;

  // range is [lo, hi) with hi exclusive
  always_comb begin
    state_next   = state;
    lo_next      = lo;
    hi_next      = hi;
    mid_next     = mid;
    key_next     = key;
    found_r_next = found_r;
    op           = '0;
    addr         = mid;
    cnt_m1       = start_count - CW'(1);
    mid0         = cnt_m1 >> 1;
    lo_n         = lo;
    hi_n         = hi;
    span_sum     = '0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          key_next = start_key;
          lo_next  = '0;
          hi_next  = start_count;
          if (start_count == '0) begin
            found_r_next = 1'b0;
            state_next   = S_DONE;
          end else begin
            op.rd      = 1'b1;
            addr       = mid0[AW-1:0];
            mid_next   = mid0[AW-1:0];
            state_next = S_PROBE;
          end
        end
      end
      S_PROBE: begin
        if (key == rd_data) begin
          found_r_next = 1'b1;
          state_next   = S_DONE;
        end else begin
          // narrow the range around the probed slot
          if (key < rd_data) begin
            hi_n = CW'(mid);
          end else begin
            lo_n = CW'(mid) + CW'(1);
          end
          lo_next = lo_n;
          hi_next = hi_n;
          if (lo_n < hi_n) begin
            span_sum = {1'b0, lo_n} + {1'b0, hi_n} - (CW+1)'(1);
            op.rd    = 1'b1;
            addr     = span_sum[AW:1];
            mid_next = span_sum[AW:1];
          end else begin
            found_r_next = 1'b0;
            state_next   = S_DONE;
          end
        end
      end
      S_DONE: begin
        if (res_take) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // search registers
  always_ff @(posedge clk) begin
    lo      <= lo_next;
    hi      <= hi_next;
    mid     <= mid_next;
    key     <= key_next;
    found_r <= found_r_next;
  end

  assign busy      = (state != S_IDLE);
  assign res_valid = (state == S_DONE);
  assign res_found = found_r;

endmodule

>>> sv/sorted_table_binary_search.sv
// top level of the sorted table membership lookup
`timescale 1ns / 1ps

// Membership lookup over a table of packed character keys kept in ascending
// order in one single port memory with a registered read. A load request
// writes key_word into slot and gives no result. A lookup request runs a
// binary search over slots 0 to entry_count-1 and gives one found result.
// The first probe address is issued in the accept cycle and each later
// cycle compares one entry and issues the next probe. A lookup makes at
// most ceil(log2(entry_count+1)) probes (14 at 8192 entries) and then
// passes its result to the output register. in_stall stays high from the
// accept until the result is taken, so no new lookup is taken while one
// runs; a stalled output register keeps it high. Keys compare
// as unsigned numbers, first character in the top byte. entry_count is to be
// written through cfg_write / cfg_data by the user only while the block is
// idle; the block itself does not enforce this. The count is saturated to
// TABLE_DEPTH. There is no clearing pass: slots must be loaded before a
// lookup can probe them. The result sits in an output register, so the
// next request is taken while a result waits.
module sorted_table_binary_search #(
  parameter int TABLE_DEPTH = 8192,
  parameter int KEY_CHARS   = 5
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [13:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [0:0]  command,
  input  logic [12:0] slot,
  input  logic [39:0] key_word,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        found
);
  import sts_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int KW = 8 * KEY_CHARS;

  logic [13:0]   entry_count;
  logic [CW-1:0] n_sat;
  logic [63:0]   key_ext;
  logic [KW-1:0] key;
  logic [31:0]   slot_ext;
  logic          slot_ok;
  logic          accept;
  logic          lookup_go;
  logic          load_go;
  mem_op_t       srch_op;
  logic [AW-1:0] srch_addr;
  mem_op_t       mem_op;
  logic [AW-1:0] mem_addr;
  logic [KW-1:0] rd_data;
  logic          busy;
  logic          res_valid;
  logic          res_found;
  logic          res_take;

  // entry count register
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
    end else if (cfg_write) begin
      entry_count <= cfg_data;
    end
  end

  // saturate count and trim key to the stored width
  always_comb begin
    if (32'(entry_count) > 32'(TABLE_DEPTH)) begin
      n_sat = CW'(TABLE_DEPTH);
    end else begin
      n_sat = CW'(entry_count);
    end
    key_ext  = 64'(key_word);
    key      = key_ext[KW-1:0];
    slot_ext = 32'(slot);
    slot_ok  = (slot_ext < 32'(TABLE_DEPTH));
  end

  // request decode
  assign in_stall  = busy;
  assign accept    = in_valid && !in_stall;
  assign lookup_go = accept && (command == CMD_LOOKUP);
  assign load_go   = accept && (command == CMD_LOAD) && slot_ok;

  sts_search #(
    .AW (AW),
    .CW (CW),
    .KW (KW)
  ) u_search (
    .clk         (clk),
    .rst         (rst),
    .start       (lookup_go),
    .start_key   (key),
    .start_count (n_sat),
    .rd_data     (rd_data),
    .op          (srch_op),
    .addr        (srch_addr),
    .busy        (busy),
    .res_valid   (res_valid),
    .res_found   (res_found),
    .res_take    (res_take)
  );

  // table port: loads only happen while the search is idle
  always_comb begin
    mem_op.wr = load_go;
    mem_op.rd = srch_op.rd;
    mem_addr  = load_go ? slot_ext[AW-1:0] : srch_addr;
  end

  sts_table #(
    .DEPTH (TABLE_DEPTH),
    .AW    (AW),
    .KW    (KW)
  ) u_table (
    .clk     (clk),
    .op      (mem_op),
    .addr    (mem_addr),
    .wr_data (key),
    .rd_data (rd_data)
  );

  // output register
  assign res_take = res_valid && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      found <= res_found;
    end
  end

endmodule
